// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the RTL of the page deframer.
// Each macro takes a label, the clock, the active-low reset, a property and a message.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, prop, msg)
`endif
`endif

// ===== hdl/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg
// Types, constants and the CRC-32C byte update of the page deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam int DEFAULT_PHYS_PAGE_BYTES    = 1024;
  localparam int DEFAULT_LOGICAL_PAGE_BYTES = 1020;
  localparam int DEFAULT_QUEUE_DEPTH        = 2;

  localparam int BYTE_W     = 8;
  localparam int OFFSET_W   = 10;
  localparam int PAGE_IDX_W = 32;
  localparam int CRC_W      = 32;
  localparam int SUM_HIST_W = 24;

  localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'h82F6_3B78;
  localparam logic [CRC_W-1:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_XOR_OUT   = 32'hFFFF_FFFF;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // What the front end decided about one byte of the physical stream.
  typedef enum logic [1:0] {
    CMD_PAYLOAD,
    CMD_SUM,
    CMD_VERDICT
  } cmd_e;

  typedef struct packed {
    cmd_e                op;
    logic                restart;
    logic [BYTE_W-1:0]   data;
    logic [OFFSET_W-1:0] offset;
  } cmd_t;

  // Reflected CRC-32C update by one byte, least significant bit first.
  function automatic logic [CRC_W-1:0] crc32c_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/cpd_if.sv =====
// ----------------------------------------------------------------------------
// cpd_in_if / cpd_out_if
// Valid-ready channels for raw stream bytes and for deframed results.
// ----------------------------------------------------------------------------
interface cpd_in_if;
  import cpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              page_start;

  modport source (output valid, output byte_in, output page_start, input ready);
  modport sink   (input valid, input byte_in, input page_start, output ready);
endinterface

interface cpd_out_if;
  import cpd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [BYTE_W-1:0]     data_byte;
  logic [OFFSET_W-1:0]   byte_offset;
  logic                  page_ok;
  logic [PAGE_IDX_W-1:0] page_index;

  modport source (output valid, output kind, output data_byte, output byte_offset,
                  output page_ok, output page_index, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_offset,
                  input page_ok, input page_index, output ready);
endinterface

// ===== hdl/cpd_front.sv =====
// ----------------------------------------------------------------------------
// cpd_front
// Tracks the position in the physical page and classifies each byte.
// ----------------------------------------------------------------------------
module cpd_front #(
  parameter int PHYS_PAGE_BYTES    = cpd_pkg::DEFAULT_PHYS_PAGE_BYTES,
  parameter int LOGICAL_PAGE_BYTES = cpd_pkg::DEFAULT_LOGICAL_PAGE_BYTES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cpd_in_if.sink        in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output cpd_pkg::cmd_t push_cmd_o
);
  import cpd_pkg::*;

  localparam int PosMax = (PHYS_PAGE_BYTES - 1 > LOGICAL_PAGE_BYTES) ?
                          PHYS_PAGE_BYTES - 1 : LOGICAL_PAGE_BYTES;
  localparam int PosW   = $clog2(PosMax + 1);

  localparam logic [PosW-1:0] LogLimit = PosW'(LOGICAL_PAGE_BYTES);
  localparam logic [PosW-1:0] PhysLast = PosW'(PHYS_PAGE_BYTES - 1);

  logic [PosW-1:0]          pos_q, pos_d;
  logic [PosW-1:0]          pos_base;
  logic [PosW+OFFSET_W-1:0] pos_ext;
  logic                     accept;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  assign pos_base = in_i.page_start ? '0 : pos_q;
  assign pos_ext  = {{OFFSET_W{1'b0}}, pos_base};

  always_comb begin
    push_cmd_o.restart = in_i.page_start;
    push_cmd_o.data    = in_i.byte_in;
    push_cmd_o.offset  = pos_ext[OFFSET_W-1:0];
    if (pos_base < LogLimit) begin
      push_cmd_o.op = CMD_PAYLOAD;
      pos_d         = pos_base + 1'b1;
    end else if (pos_base < PhysLast) begin
      push_cmd_o.op = CMD_SUM;
      pos_d         = pos_base + 1'b1;
    end else begin
      push_cmd_o.op = CMD_VERDICT;
      pos_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== hdl/cpd_queue.sv =====
// ----------------------------------------------------------------------------
// cpd_queue
// Small FIFO of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpd_queue #(
  parameter int Depth = cpd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  cpd_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output cpd_pkg::cmd_t pop_cmd_o
);
  import cpd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ASSERT_PROP(a_count_bound, clk_i, rst_ni, count_q <= FullCnt, "queue count over depth")
  `ASSERT_PROP(a_fill, clk_i, rst_ni, (push && !pop) |=> (count_q == $past(count_q) + 1'b1), "queue fill lost")
  `ASSERT_PROP(a_drain, clk_i, rst_ni, (pop && !push) |=> (count_q == $past(count_q) - 1'b1), "queue drain lost")
  `ASSERT_NEVER(a_ptr_gap, clk_i, rst_ni, (count_q == '0) && (wr_ptr_q != rd_ptr_q), "pointers apart when empty")

endmodule

// ===== hdl/cpd_back.sv =====
// ----------------------------------------------------------------------------
// cpd_back
// Runs the CRC-32C, collects the stored sum and registers the results.
// ----------------------------------------------------------------------------
module cpd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  cpd_pkg::cmd_t pop_cmd_i,
  cpd_out_if.source     out_o
);
  import cpd_pkg::*;

  logic [CRC_W-1:0]      crc_q, crc_d, crc_base;
  logic [SUM_HIST_W-1:0] sum_q, sum_d, sum_base;
  logic [PAGE_IDX_W-1:0] page_cnt_q, page_cnt_d;
  logic [CRC_W-1:0]      sum_word;

  logic                  out_valid_q;
  logic                  kind_q, kind_d;
  logic [BYTE_W-1:0]     data_q, data_d;
  logic [OFFSET_W-1:0]   offset_q, offset_d;
  logic                  ok_q, ok_d;
  logic [PAGE_IDX_W-1:0] index_q;
  logic                  emit, pop;

  // The output register takes a new result whenever it is empty or being drained.
  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  assign crc_base = pop_cmd_i.restart ? CRC_INIT : crc_q;
  assign sum_base = pop_cmd_i.restart ? '0 : sum_q;
  assign sum_word = {sum_base, pop_cmd_i.data};

  always_comb begin
    crc_d      = crc_base;
    sum_d      = sum_base;
    page_cnt_d = page_cnt_q;
    emit       = 1'b0;
    kind_d     = KIND_PAYLOAD;
    data_d     = '0;
    offset_d   = '0;
    ok_d       = 1'b0;
    unique case (pop_cmd_i.op)
      CMD_PAYLOAD: begin
        crc_d    = crc32c_byte(crc_base, pop_cmd_i.data);
        emit     = 1'b1;
        data_d   = pop_cmd_i.data;
        offset_d = pop_cmd_i.offset;
      end
      CMD_SUM: begin
        sum_d = {sum_base[SUM_HIST_W-BYTE_W-1:0], pop_cmd_i.data};
      end
      CMD_VERDICT: begin
        emit       = 1'b1;
        kind_d     = KIND_VERDICT;
        ok_d       = (sum_word == (crc_base ^ CRC_XOR_OUT));
        crc_d      = CRC_INIT;
        sum_d      = '0;
        page_cnt_d = page_cnt_q + 1'b1;
      end
      default: begin
        crc_d = crc_base;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      sum_q       <= '0;
      page_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        crc_q      <= crc_d;
        sum_q      <= sum_d;
        page_cnt_q <= page_cnt_d;
      end
      if (pop_ready_o) begin
        out_valid_q <= pop && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      kind_q   <= kind_d;
      data_q   <= data_d;
      offset_q <= offset_d;
      ok_q     <= ok_d;
      index_q  <= page_cnt_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = kind_q;
  assign out_o.data_byte   = data_q;
  assign out_o.byte_offset = offset_q;
  assign out_o.page_ok     = ok_q;
  assign out_o.page_index  = index_q;

endmodule

// ===== hdl/crc_checked_page_deframer.sv =====
// ----------------------------------------------------------------------------
// crc_checked_page_deframer
// Path: each accepted byte is held in a queue entry, and its result in the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the byte-wise CRC-32C update.
// Reset: asynchronous, clears position, stored sum and page count, CRC to all ones.
// No clearing pass is needed; the block accepts bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module crc_checked_page_deframer #(
  parameter int PHYS_PAGE_BYTES    = cpd_pkg::DEFAULT_PHYS_PAGE_BYTES,
  parameter int LOGICAL_PAGE_BYTES = cpd_pkg::DEFAULT_LOGICAL_PAGE_BYTES,
  parameter int QUEUE_DEPTH        = cpd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpd_in_if.sink    in_i,
  cpd_out_if.source out_o
);
  import cpd_pkg::*;

  // The front end only tracks where each byte sits in the physical page. It
  // marks every byte as payload, stored checksum or last checksum byte, and a
  // set page_start flag restarts alignment so that the byte becomes offset 0.
  // A transaction is taken from the input whenever the queue has room.
  logic push_valid, push_ready;
  cmd_t push_cmd;

  // The queue decouples the two halves, so a stalled output does not stop the
  // input until the queue and the output register are both full.
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  cpd_front #(
    .PHYS_PAGE_BYTES    (PHYS_PAGE_BYTES),
    .LOGICAL_PAGE_BYTES (LOGICAL_PAGE_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  cpd_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // The back end owns the CRC register, the stored-sum history and the page
  // counter. Payload bytes leave as kind-0 transactions, checksum bytes are
  // absorbed, and the last checksum byte leaves as a verdict with page_ok.
  cpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_o       (out_o)
  );

endmodule
